// ===== design/ati_pkg.sv =====
// Shared types and constants for the ADC table interpolator.
package ati_pkg;

    localparam int ADC_W        = 16;
    localparam int TEMP_W       = 16;
    localparam int IDX_W        = 6;
    localparam int SIZE_W       = 7;
    localparam int TABLE_DEPTH_DEF = 64;

    // serial divider operand widths: |dtemp * dadc| < 2^32, |dadc| < 2^16
    localparam int DIVIDEND_W   = 32;
    localparam int DIVISOR_W    = 16;
    localparam int PROD_W       = 34;
    localparam int DIFF_W       = 17;

    localparam logic signed [TEMP_W-1:0] DEFAULT_TEMP = 16'sd300;
    localparam logic signed [PROD_W-1:0] TEMP_MAX = 34'sd32767;
    localparam logic signed [PROD_W-1:0] TEMP_MIN = -34'sd32768;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    typedef struct packed {
        logic        [ADC_W-1:0]  adc;
        logic signed [TEMP_W-1:0] temp;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_RLO,
        S_RHI,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// ===== design/ati_in_if.sv =====
// Input channel: load and convert beats.
interface ati_in_if import ati_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic        [IDX_W-1:0]  entry_index;
    logic        [ADC_W-1:0]  entry_adc;
    logic signed [TEMP_W-1:0] entry_temp;
    logic        [ADC_W-1:0]  sample_adc;

    modport source (output valid, action, entry_index, entry_adc, entry_temp, sample_adc,
                    input ready);
    modport sink (input valid, action, entry_index, entry_adc, entry_temp, sample_adc,
                  output ready);
endinterface

// ===== design/ati_out_if.sv =====
// Output channel: converted temperature beats.
interface ati_out_if import ati_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, temperature, input ready);
    modport sink (input valid, temperature, output ready);
endinterface

// ===== design/adc_table_interpolator.sv =====
// Top level: ADC-to-temperature conversion by piecewise-linear table lookup.
// A load beat writes one calibration entry. A convert beat runs a small
// sequencer over the table memory, which has one registered read port, so
// each table access is registered: an empty table answers with the default
// temperature, a sample at or beyond either end with that end's entry after
// reading the first or also the last entry, an exact hit after k search steps
// (k <= log2(table_size) + 1), and an interpolated result after the two
// bracketing reads, a multiply and the 32-step serial divider. The result
// is held in an output register until taken; no new beat is accepted until then.
module adc_table_interpolator import ati_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    ati_in_if.sink            i_in,
    ati_out_if.source         o_out
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state                   r_state, n_state;
    logic [SIZE_W-1:0]        r_table_size;
    logic [ADC_W-1:0]         r_sample, n_sample;
    logic [AW-1:0]            r_lo, n_lo;
    logic [AW-1:0]            r_hi, n_hi;
    logic [AW-1:0]            r_mid, n_mid;
    logic [ADC_W-1:0]         r_adc_lo, n_adc_lo;
    logic signed [TEMP_W-1:0] r_temp_lo, n_temp_lo;
    logic signed [TEMP_W-1:0] r_temp_hi, n_temp_hi;
    logic signed [DIFF_W-1:0] r_tdiff, n_tdiff;
    logic signed [DIFF_W-1:0] r_adiff, n_adiff;
    logic signed [DIFF_W-1:0] r_den, n_den;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                     r_neg, n_neg;
    logic                     r_out_valid, n_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp, n_out_temp;

    logic [CW-1:0]            n_used;
    logic [AW-1:0]            last;
    logic                     in_acc;
    logic                     idx_ok;
    logic                     mem_we;
    logic [AW-1:0]            rd_addr;
    t_entry                   wr_entry;
    t_entry                   rd;
    logic [AW-1:0]            lo2, hi2;
    logic [AW:0]              mid_sum;
    logic signed [DIFF_W-1:0] den_c;
    logic signed [PROD_W-1:0] prod_mag;
    logic signed [DIFF_W-1:0] den_mag;
    logic signed [PROD_W-1:0] q_ext;
    logic signed [PROD_W-1:0] res;
    logic                     div_start;
    logic [DIVIDEND_W-1:0]    div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic                     div_done;
    logic [DIVIDEND_W-1:0]    div_quotient;

    assign n_used = (32'(r_table_size) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(r_table_size);
    assign last   = AW'(n_used - 1'b1);
    assign in_acc = i_in.valid && i_in.ready;
    assign idx_ok = 32'(i_in.entry_index) < TABLE_DEPTH;
    assign mem_we = in_acc && (i_in.action == ACT_LOAD) && idx_ok;
    assign wr_entry.adc  = i_in.entry_adc;
    assign wr_entry.temp = i_in.entry_temp;

    ati_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_in.entry_index)),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd)
    );

    ati_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_sample    = r_sample;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_adc_lo    = r_adc_lo;
        n_temp_lo   = r_temp_lo;
        n_temp_hi   = r_temp_hi;
        n_tdiff     = r_tdiff;
        n_adiff     = r_adiff;
        n_den       = r_den;
        n_prod      = r_prod;
        n_neg       = r_neg;
        n_out_valid = r_out_valid;
        n_out_temp  = r_out_temp;
        rd_addr     = '0;
        lo2         = r_lo;
        hi2         = r_hi;
        mid_sum     = '0;
        den_c       = $signed({1'b0, r_adc_lo}) - $signed({1'b0, rd.adc});
        prod_mag    = r_prod[PROD_W-1] ? -r_prod : r_prod;
        den_mag     = r_den[DIFF_W-1] ? -r_den : r_den;
        q_ext       = $signed({2'b00, div_quotient});
        res         = '0;
        div_start   = 1'b0;
        div_dividend = prod_mag[DIVIDEND_W-1:0];
        div_divisor  = den_mag[DIVISOR_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.action == ACT_CONVERT)) begin
                    n_sample = i_in.sample_adc;
                    if (n_used == '0) begin
                        n_out_valid = 1'b1;
                        n_out_temp  = DEFAULT_TEMP;
                        n_state     = S_OUT;
                    end else begin
                        rd_addr = '0;
                        n_state = S_FIRST;
                    end
                end
            end
            S_FIRST: begin
                if (rd.adc >= r_sample) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = rd.temp;
                    n_state     = S_OUT;
                end else begin
                    rd_addr = last;
                    n_lo    = '0;
                    n_hi    = last;
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                if (rd.adc <= r_sample) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = rd.temp;
                    n_state     = S_OUT;
                end else begin
                    mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
                    n_mid   = mid_sum[AW:1];
                    rd_addr = mid_sum[AW:1];
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                // the first entry is below the sample and the last above it,
                // so lo and hi stay inside the table
                if (rd.adc == r_sample) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = rd.temp;
                    n_state     = S_OUT;
                end else begin
                    if (rd.adc > r_sample) begin
                        hi2 = r_mid - 1'b1;
                    end else begin
                        lo2 = r_mid + 1'b1;
                    end
                    n_lo = lo2;
                    n_hi = hi2;
                    if (lo2 <= hi2) begin
                        mid_sum = {1'b0, lo2} + {1'b0, hi2};
                        n_mid   = mid_sum[AW:1];
                        rd_addr = mid_sum[AW:1];
                    end else begin
                        rd_addr = lo2;
                        n_state = S_RLO;
                    end
                end
            end
            S_RLO: begin
                n_adc_lo  = rd.adc;
                n_temp_lo = rd.temp;
                rd_addr   = r_hi;
                n_state   = S_RHI;
            end
            S_RHI: begin
                if (den_c == '0) begin
                    n_out_valid = 1'b1;
                    n_out_temp  = rd.temp;
                    n_state     = S_OUT;
                end else begin
                    n_temp_hi = rd.temp;
                    n_den     = den_c;
                    n_tdiff   = $signed({r_temp_lo[TEMP_W-1], r_temp_lo})
                              - $signed({rd.temp[TEMP_W-1], rd.temp});
                    n_adiff   = $signed({1'b0, r_sample}) - $signed({1'b0, rd.adc});
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_tdiff * r_adiff;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_neg     = r_prod[PROD_W-1] ^ r_den[DIFF_W-1];
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    // quotient magnitude, sign restored: truncation toward zero
                    res = $signed({{(PROD_W-TEMP_W){r_temp_hi[TEMP_W-1]}}, r_temp_hi})
                        + (r_neg ? -q_ext : q_ext);
                    n_out_valid = 1'b1;
                    if (res > TEMP_MAX) begin
                        n_out_temp = TEMP_MAX[TEMP_W-1:0];
                    end else if (res < TEMP_MIN) begin
                        n_out_temp = TEMP_MIN[TEMP_W-1:0];
                    end else begin
                        n_out_temp = res[TEMP_W-1:0];
                    end
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample   <= n_sample;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_adc_lo   <= n_adc_lo;
        r_temp_lo  <= n_temp_lo;
        r_temp_hi  <= n_temp_hi;
        r_tdiff    <= n_tdiff;
        r_adiff    <= n_adiff;
        r_den      <= n_den;
        r_prod     <= n_prod;
        r_neg      <= n_neg;
        r_out_temp <= n_out_temp;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.temperature = r_out_temp;

endmodule

// ===== design/ati_table.sv =====
// Calibration table memory: one write port, one registered read port.
module ati_table import ati_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/ati_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module ati_div import ati_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_div, n_div;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        trial  = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = trial - {1'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // dividend bits shift out the top while quotient bits enter the bottom
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIVISOR_W-1:0];
                n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/ati_checker.sv =====
// Port-level checks for the ADC table interpolator, bound to the top level.
module ati_checker import ati_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_action,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [TEMP_W-1:0] i_out_temp
);

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_temp))
        else $error("result beat dropped or changed while stalled");

    // one conversion at a time
    a_convert_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_CONVERT) |=> !i_in_ready)
        else $error("input accepted while a conversion is in flight");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input ready while a result is pending");

    // a load never produces a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_LOAD) |=> !i_out_valid)
        else $error("result appeared after a load beat");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind adc_table_interpolator ati_checker u_ati_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.action),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_temp  (o_out.temperature)
);
